### rtl/core/ranp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranp_pkg
// Shared types, character codes and helpers for the radix alphabet parser.
// ----------------------------------------------------------------------------
package ranp_pkg;

   // largest alphabet the design supports
   localparam int MAX_DIGITS_DEFAULT = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_ALPHABET_LOW    = 2'd0;
   localparam logic [1:0] CSR_ALPHABET_HIGH   = 2'd1;
   localparam logic [1:0] CSR_ALPHABET_LENGTH = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_VT    = 8'h0b;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   // input word
   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final;
   } req_payload_type;

   // result word
   typedef struct packed {
      logic signed [31:0] parsed_value;
      logic               alphabet_bad;
   } rsp_payload_type;

   // classification of one text byte
   typedef struct packed {
      logic       is_space;
      logic       is_plus;
      logic       is_minus;
      logic       hit;
      logic [3:0] digit;
   } char_class_type;

   // whitespace test
   function automatic logic is_space_char(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
             (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
   endfunction

endpackage

### rtl/core/radix_alphabet_number_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_alphabet_number_parser
// Streaming signed number parser over a configurable digit alphabet.
// ----------------------------------------------------------------------------
// Timing: a final byte is held in the byte register, then its result word in the
//    result register.
// Throughput: one byte per cycle; only a final byte waits, and only while a
//    result word is held by the receiver.
// The per-byte path is the alphabet compare plus one 32x5 multiply-add.
// Reset (synchronous): clears parse state, configuration and both valids.
// ----------------------------------------------------------------------------
module radix_alphabet_number_parser #(
   parameter int MAX_DIGITS = ranp_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // input words
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ranp_pkg::req_payload_type  req_payload,
   // result words
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ranp_pkg::rsp_payload_type  rsp_payload,
   // configuration writes
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [63:0]                csr_write_data
);
   import ranp_pkg::*;

   localparam logic [1:0] PHASE_SPACE = 2'd0;
   localparam logic [1:0] PHASE_SIGN  = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;
   localparam logic [1:0] PHASE_STOP  = 2'd3;

   // configuration registers
   logic [63:0] alphabet_low_ff;
   logic [63:0] alphabet_high_ff;
   logic [4:0]  alphabet_length_ff;
   logic        alphabet_bad_ff;
   logic        alphabet_bad_in;

   // byte register
   logic            byte_valid_ff;
   req_payload_type byte_ff;

   // parse state
   logic [1:0]  phase_ff;
   logic [1:0]  phase_in;
   logic        negative_ff;
   logic        negative_in;
   logic [31:0] acc_ff;
   logic [31:0] acc_in;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   char_class_type char_class;
   logic           out_free;
   logic           advance;

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_low_ff    <= '0;
         alphabet_high_ff   <= '0;
         alphabet_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ALPHABET_LOW:    alphabet_low_ff    <= csr_write_data;
            CSR_ALPHABET_HIGH:   alphabet_high_ff   <= csr_write_data;
            CSR_ALPHABET_LENGTH: alphabet_length_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // alphabet validity, judged from the configuration registers and registered
   ranp_alphabet_check #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_check (
      .alphabet_low    (alphabet_low_ff),
      .alphabet_high   (alphabet_high_ff),
      .alphabet_length (alphabet_length_ff),
      .alphabet_bad    (alphabet_bad_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_bad_ff <= 1'b1;
      end else begin
         alphabet_bad_ff <= alphabet_bad_in;
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = byte_valid_ff && (!byte_ff.is_final || out_free);
   assign req_ready = !byte_valid_ff || advance;

   // byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_ready) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_payload;
      end
   end

   // byte classification
   ranp_digit_lookup #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_lookup (
      .text_byte       (byte_ff.text_byte),
      .alphabet_low    (alphabet_low_ff),
      .alphabet_high   (alphabet_high_ff),
      .alphabet_length (alphabet_length_ff),
      .char_class      (char_class)
   );

   // phase step
   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      if (phase_ff != PHASE_STOP) begin
         if ((phase_ff == PHASE_SPACE) && char_class.is_space) begin
            phase_in = PHASE_SPACE;
         end else if (((phase_ff == PHASE_SPACE) || (phase_ff == PHASE_SIGN)) &&
                      (char_class.is_plus || char_class.is_minus)) begin
            negative_in = negative_ff ^ char_class.is_minus;
            phase_in    = PHASE_SIGN;
         end else if (char_class.hit) begin
            acc_in   = 32'(acc_ff * {27'd0, alphabet_length_ff}) + {28'd0, char_class.digit};
            phase_in = PHASE_DIGIT;
         end else begin
            phase_in = PHASE_STOP;
         end
      end
   end

   // signed result of the string
   always_comb begin
      if (alphabet_bad_ff) begin
         rsp_in.parsed_value = '0;
         rsp_in.alphabet_bad = 1'b1;
      end else begin
         rsp_in.parsed_value = negative_in ? -acc_in : acc_in;
         rsp_in.alphabet_bad = 1'b0;
      end
   end

   // parse state, cleared after each string
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_SPACE;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
      end else if (advance) begin
         if (byte_ff.is_final) begin
            phase_ff    <= PHASE_SPACE;
            negative_ff <= 1'b0;
            acc_ff      <= '0;
         end else begin
            phase_ff    <= phase_in;
            negative_ff <= negative_in;
            acc_ff      <= acc_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && byte_ff.is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && byte_ff.is_final) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/ranp_digit_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranp_digit_lookup
// Classifies one text byte: whitespace, sign, or its place in the alphabet.
// ----------------------------------------------------------------------------
module ranp_digit_lookup #(
   parameter int MAX_DIGITS = ranp_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic [7:0]                text_byte,
   input  logic [63:0]               alphabet_low,
   input  logic [63:0]               alphabet_high,
   input  logic [4:0]                alphabet_length,
   output ranp_pkg::char_class_type  char_class
);
   import ranp_pkg::*;

   logic [127:0] alphabet_bits;
   logic         hit;
   logic [3:0]   digit;

   assign alphabet_bits = {alphabet_high, alphabet_low};

   // parallel compares, lowest matching position wins
   always_comb begin
      hit   = 1'b0;
      digit = 4'd0;
      for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
         if ((5'(i) < alphabet_length) && (alphabet_bits[8*i +: 8] == text_byte)) begin
            hit   = 1'b1;
            digit = 4'(i);
         end
      end
   end

   // a zero byte ends the string and is never a digit
   always_comb begin
      char_class.is_space = is_space_char(text_byte);
      char_class.is_plus  = (text_byte == CHAR_PLUS);
      char_class.is_minus = (text_byte == CHAR_MINUS);
      char_class.hit      = hit && (text_byte != CHAR_NUL);
      char_class.digit    = digit;
   end

endmodule

### rtl/core/ranp_alphabet_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranp_alphabet_check
// Judges whether the configured alphabet is usable as a digit set.
// ----------------------------------------------------------------------------
module ranp_alphabet_check #(
   parameter int MAX_DIGITS = ranp_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic [63:0] alphabet_low,
   input  logic [63:0] alphabet_high,
   input  logic [4:0]  alphabet_length,
   output logic        alphabet_bad
);
   import ranp_pkg::*;

   localparam logic [4:0] MaxLen = 5'(MAX_DIGITS);

   logic [127:0] alphabet_bits;
   logic         length_bad;
   logic         char_bad;
   logic         repeat_bad;

   assign alphabet_bits = {alphabet_high, alphabet_low};
   assign length_bad    = (alphabet_length < 5'd2) || (alphabet_length > MaxLen);

   // forbidden characters in the used part
   always_comb begin
      char_bad = 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (5'(i) < alphabet_length) begin
            if ((alphabet_bits[8*i +: 8] == CHAR_NUL) ||
                (alphabet_bits[8*i +: 8] == CHAR_PLUS) ||
                (alphabet_bits[8*i +: 8] == CHAR_MINUS) ||
                is_space_char(alphabet_bits[8*i +: 8])) begin
               char_bad = 1'b1;
            end
         end
      end
   end

   // pairwise duplicate search
   always_comb begin
      repeat_bad = 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         for (int j = i + 1; j < MAX_DIGITS; j++) begin
            if ((5'(j) < alphabet_length) &&
                (alphabet_bits[8*i +: 8] == alphabet_bits[8*j +: 8])) begin
               repeat_bad = 1'b1;
            end
         end
      end
   end

   assign alphabet_bad = length_bad || char_bad || repeat_bad;

endmodule

### rtl/core/ranp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranp_checker
// Port-level checks for the radix alphabet parser, bound to the top level.
// ----------------------------------------------------------------------------
module ranp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input ranp_pkg::req_payload_type  req_payload,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input ranp_pkg::rsp_payload_type  rsp_payload,
   input logic                       csr_write_enable,
   input logic [1:0]                 csr_index,
   input logic [63:0]                csr_write_data
);
   import ranp_pkg::*;

   logic final_accept;

   assign final_accept = req_valid && req_ready && req_payload.is_final;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // nothing pending after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a bad alphabet forces a zero value
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.alphabet_bad |-> rsp_payload.parsed_value == 32'sd0)
      else $error("nonzero value with bad alphabet");

   // a fresh result comes from an accepted final byte, through the byte and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(final_accept, 2))
      else $error("result without a final byte");

   // the user keeps register writes to no result word waiting, known index and data; the parser does not enforce it
   a_cfg_quiet: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> !rsp_valid && !$isunknown({csr_index, csr_write_data}))
      else $error("register write while a result word waits");

endmodule

bind radix_alphabet_number_parser ranp_checker u_ranp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_payload      (req_payload),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_payload      (rsp_payload),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_write_data   (csr_write_data)
);
